@@ design/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg - shared types and constants for the sobel edge magnitude core
// Field widths, register indexes and the small arithmetic helpers of the kernel.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int PIXEL_W    = 8;
   localparam int MAG_W      = 8;
   localparam int COL_W      = 11;
   localparam int ROW_W      = 12;
   localparam int FW_W       = 12;
   localparam int FH_W       = 13;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int SUM_W      = 10;
   localparam int WIDE_W     = 16;
   localparam int MIN_DIM    = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

   // per-pixel flags from the position tracker
   typedef struct packed {
      logic emit;
      logic done;
   } tag_type;

   // a + 2b + c
   function automatic logic [SUM_W-1:0] weigh(input logic [PIXEL_W-1:0] a,
                                              input logic [PIXEL_W-1:0] b,
                                              input logic [PIXEL_W-1:0] c);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + (SUM_W'(b) << 1) + SUM_W'(c);
      return s;
   endfunction

   function automatic logic [SUM_W-1:0] absdiff(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

endpackage

@@ design/sem_ram.sv @@
// ----------------------------------------------------------------------------
// sem_ram - generic single-port-write, single-port-read ram
// One write and one registered read per cycle; read data holds when not enabled.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sem_pos.sv @@
// ----------------------------------------------------------------------------
// sem_pos - frame geometry registers and raster position tracker
// Holds the clamped frame size and the column/row of the next pixel, and flags
// whether the pixel being transferred completes an interior window.
// ----------------------------------------------------------------------------
module sem_pos
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_W-1:0]         csr_addr,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_accept,
   input  logic                          first_of_frame,
   output logic [$clog2(MAX_WIDTH)-1:0]  pos_col,
   output logic [$clog2(MAX_HEIGHT)-1:0] pos_row,
   output tag_type                       pos_tag
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [WIDE_W-1:0] MAXW = WIDE_W'(MAX_WIDTH);
   localparam logic [WIDE_W-1:0] MAXH = WIDE_W'(MAX_HEIGHT);
   localparam logic [WIDE_W-1:0] MIND = WIDE_W'(MIN_DIM);
   localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

   logic [CW:0]   width_ff, width_in;
   logic [RW:0]   height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WIDE_W-1:0] wv, hv;
   logic [CW:0]   col_ext, col_inc;
   logic [RW:0]   row_ext, row_inc;

   // size writes are clamped once, at write time
   always_comb begin
      wv = WIDE_W'(csr_wdata[FW_W-1:0]);
      hv = WIDE_W'(csr_wdata[FH_W-1:0]);
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_addr == CSR_FRAME_WIDTH) begin
         if (wv < MIND) begin
            width_in = (CW+1)'(MIND);
         end else if (wv > MAXW) begin
            width_in = (CW+1)'(MAXW);
         end else begin
            width_in = (CW+1)'(wv);
         end
      end
      if (csr_we && csr_addr == CSR_FRAME_HEIGHT) begin
         if (hv < MIND) begin
            height_in = (RW+1)'(MIND);
         end else if (hv > MAXH) begin
            height_in = (RW+1)'(MAXH);
         end else begin
            height_in = (RW+1)'(hv);
         end
      end
   end

   assign pos_col = first_of_frame ? '0 : col_ff;
   assign pos_row = first_of_frame ? '0 : row_ff;
   assign col_ext = (CW+1)'(pos_col);
   assign row_ext = (RW+1)'(pos_row);
   assign col_inc = col_ext + (CW+1)'(1);
   assign row_inc = row_ext + (RW+1)'(1);

   always_comb begin
      pos_tag.emit = (col_ext >= (CW+1)'(2)) && (col_ext < width_ff) &&
                     (row_ext >= (RW+1)'(2)) && (row_ext < height_ff);
      pos_tag.done = (col_ext == width_ff - (CW+1)'(1)) &&
                     (row_ext == height_ff - (RW+1)'(1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = (row_inc >= height_ff) ? '0 : row_inc[RW-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = pos_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= (CW+1)'(W_RST);
         height_ff <= (RW+1)'(H_RST);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

@@ design/sem_kernel.sv @@
// ----------------------------------------------------------------------------
// sem_kernel - 3x3 window, sobel gradient sum and result register
// Shifts the two left columns of the window and registers one saturated
// magnitude with its center position for the result channel.
// ----------------------------------------------------------------------------
module sem_kernel
   import sem_pkg::*;
#(
   parameter int CW = 11,
   parameter int RW = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  tag_type            tag,
   input  logic [CW-1:0]      col,
   input  logic [RW-1:0]      row,
   input  logic [PIXEL_W-1:0] px_top,
   input  logic [PIXEL_W-1:0] px_mid,
   input  logic [PIXEL_W-1:0] px_bot,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [MAG_W-1:0]   magnitude,
   output logic [COL_W-1:0]   center_column,
   output logic [ROW_W-1:0]   center_row,
   output logic               frame_done
);

   // 0..2: column c-2 top/mid/bottom, 3..5: column c-1
   logic [PIXEL_W-1:0] win_ff [6];
   logic [PIXEL_W-1:0] win_in [6];
   logic [SUM_W-1:0]   gx, gy;
   logic [SUM_W:0]     gsum;
   logic [MAG_W-1:0]   mag;
   logic [WIDE_W-1:0]  col_m1, row_m1;
   logic               valid_ff, valid_in;
   logic [MAG_W-1:0]   mag_ff;
   logic [COL_W-1:0]   ccol_ff;
   logic [ROW_W-1:0]   crow_ff;
   logic               done_ff;

   always_comb begin
      gx   = absdiff(weigh(px_top, px_mid, px_bot),
                     weigh(win_ff[0], win_ff[1], win_ff[2]));
      gy   = absdiff(weigh(win_ff[0], win_ff[3], px_top),
                     weigh(win_ff[2], win_ff[5], px_bot));
      gsum = (SUM_W+1)'(gx) + (SUM_W+1)'(gy);
      mag  = (gsum > (SUM_W+1)'(MAG_MAX)) ? MAG_MAX : gsum[MAG_W-1:0];
      col_m1 = WIDE_W'(col) - WIDE_W'(1);
      row_m1 = WIDE_W'(row) - WIDE_W'(1);
   end

   always_comb begin
      win_in = win_ff;
      if (advance) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = px_top;
         win_in[4] = px_mid;
         win_in[5] = px_bot;
      end
   end

   always_comb begin
      if (advance && tag.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tag.emit) begin
         mag_ff  <= mag;
         ccol_ff <= col_m1[COL_W-1:0];
         crow_ff <= row_m1[ROW_W-1:0];
         done_ff <= tag.done;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign magnitude     = mag_ff;
   assign center_column = ccol_ff;
   assign center_row    = crow_ff;
   assign frame_done    = done_ff;

endmodule

@@ design/sobel_edge_magnitude_core.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core - streaming 3x3 sobel edge magnitude
// Raster-order grayscale pixels in, |Gx|+|Gy| of interior pixels out.
//
//   channel   dir   contents
//   req_*     in    tdata: pixel[7:0]; tuser: first_of_frame
//   rsp_*     out   tdata: magnitude[7:0], center_column[18:8],
//                   center_row[30:19], zero[31]; tlast: frame_done
//   csr_*     in    index 0 frame_width (12b), index 1 frame_height (13b)
//
// One pixel per clock sustained while the input is not stalled; the transfer of a
// pixel launches the line store read and loads stage a, and the advance of stage a
// then loads the gradient register, from which the result is valid.
// The input stalls only while a pixel that yields a result sits behind a full
// result register that is stalled.
// Reset (synchronous) clears counters, window and valid flags; the line
// stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // [0] first_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] magnitude, [18:8] center_column,
                                              // [30:19] center_row, [31] zero
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic               req_accept, advance, fwd_in;
   logic [CW-1:0]      pos_col;
   logic [RW-1:0]      pos_row;
   tag_type            pos_tag;

   // stage a: pixel waiting for its line store reads
   logic               a_valid_ff, a_valid_in;
   logic [PIXEL_W-1:0] a_px_ff;
   logic [CW-1:0]      a_col_ff;
   logic [RW-1:0]      a_row_ff;
   tag_type            a_tag_ff;
   logic               a_fwd_ff;
   logic [PIXEL_W-1:0] a_byp_top_ff, a_byp_mid_ff;

   logic [PIXEL_W-1:0] top_q, mid_q, a_top, a_mid;
   logic [MAG_W-1:0]   magnitude;
   logic [COL_W-1:0]   center_column;
   logic [ROW_W-1:0]   center_row;
   logic               frame_done;

   assign advance    = a_valid_ff && (!a_tag_ff.emit || !rsp_tvalid || rsp_tready);
   assign req_tready = !a_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign a_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);
   // the line store write of the leaving pixel and the read of the new one hit
   // the same column only when a frame restarts early
   assign fwd_in     = advance && (a_col_ff == pos_col);

   sem_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_pos (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_accept     (req_accept),
      .first_of_frame (req_tuser),
      .pos_col        (pos_col),
      .pos_row        (pos_row),
      .pos_tag        (pos_tag)
   );

   // row r-2 store
   sem_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_top_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (a_col_ff),
      .wr_data (a_mid),
      .rd_en   (req_accept),
      .rd_addr (pos_col),
      .rd_data (top_q)
   );

   // row r-1 store
   sem_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_mid_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (a_col_ff),
      .wr_data (a_px_ff),
      .rd_en   (req_accept),
      .rd_addr (pos_col),
      .rd_data (mid_q)
   );

   assign a_top = a_fwd_ff ? a_byp_top_ff : top_q;
   assign a_mid = a_fwd_ff ? a_byp_mid_ff : mid_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_px_ff      <= req_tdata[PIXEL_W-1:0];
         a_col_ff     <= pos_col;
         a_row_ff     <= pos_row;
         a_tag_ff     <= pos_tag;
         a_fwd_ff     <= fwd_in;
         a_byp_top_ff <= a_mid;
         a_byp_mid_ff <= a_px_ff;
      end
   end

   sem_kernel #(
      .CW (CW),
      .RW (RW)
   ) u_kernel (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .tag           (a_tag_ff),
      .col           (a_col_ff),
      .row           (a_row_ff),
      .px_top        (a_top),
      .px_mid        (a_mid),
      .px_bot        (a_px_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .magnitude     (magnitude),
      .center_column (center_column),
      .center_row    (center_row),
      .frame_done    (frame_done)
   );

   assign rsp_tdata = {1'b0, center_row, center_column, magnitude};
   assign rsp_tlast = frame_done;

endmodule

@@ design/sem_chk.sv @@
// ----------------------------------------------------------------------------
// sem_chk - port-level checks for the sobel edge magnitude core
// Watches the two stream channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sem_chk
   import sem_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input only backs up behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // the top bit of a result transfer is padding
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[RSP_DATA_W-1])
      else $error("result pad bit set");

endmodule

bind sobel_edge_magnitude_core sem_chk u_sem_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
